/* hdl/dbn_pkg.sv */
package dbn_pkg;

  // Defaults for the top-level parameters.
  localparam int MaxBoxesDef  = 64;
  localparam int CoordFracDef = 4;
  localparam int PixelBitsDef = 12;

  // Fixed field widths of the interface.
  localparam int CoordW   = 16;
  localparam int ScoreW   = 16;
  localparam int ClassW   = 8;
  localparam int OutPixW  = 12;
  localparam int PadW     = 12;
  localparam int ScaleW   = 24;
  localparam int FrameW   = 13;
  localparam int CfgDataW = 24;
  localparam int CfgIdxW  = 3;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_CONF_THR,
    REG_IOU_THR,
    REG_BOX_FMT,
    REG_PAD_X,
    REG_PAD_Y,
    REG_INV_SCALE,
    REG_FRAME_W,
    REG_FRAME_H
  } cfg_reg_e;

  // Operation broadcast to every cell of the sorted store.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT,
    OP_CMP_A,
    OP_CMP_B
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [ScoreW-1:0]   iou_thr;
  } cell_ctrl_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_RUN,
    ST_DRAIN,
    ST_CMP_A,
    ST_CMP_B,
    ST_SHIFT,
    ST_FINAL
  } state_e;

  // Settings seen by the decode pipeline.
  typedef struct packed {
    logic [ScoreW-1:0] conf_thr;
    logic              box_fmt;
    logic [PadW-1:0]   pad_x;
    logic [PadW-1:0]   pad_y;
    logic [ScaleW-1:0] inv_scale;
    logic [FrameW-1:0] frame_w;
    logic [FrameW-1:0] frame_h;
  } dec_cfg_t;

  // Layout of one store entry, from bit 0 up:
  // x1, y1, x2, y2 (pix bits each), area (2*pix), score, class, suppressed, valid.
  function automatic int ent_width(int pix);
    return 6 * pix + ScoreW + ClassW + 2;
  endfunction

  function automatic int ent_area_lsb(int pix);
    return 4 * pix;
  endfunction

  function automatic int ent_score_lsb(int pix);
    return 6 * pix;
  endfunction

  function automatic int ent_class_lsb(int pix);
    return 6 * pix + ScoreW;
  endfunction

  function automatic int ent_supp_bit(int pix);
    return 6 * pix + ScoreW + ClassW;
  endfunction

  function automatic int ent_valid_bit(int pix);
    return 6 * pix + ScoreW + ClassW + 1;
  endfunction

endpackage

/* hdl/detection_box_decode_nms_top.sv */
// Channel   | Handshake          | Payload
// ----------+--------------------+------------------------------------------------
// candidate | start_i / busy_o   | coord_a_i..coord_d_i, score_i, class_id_i, last_i
// result    | res_valid_o strobe | box_x1_o..box_y2_o, out_score_o, out_class_o,
//           |                    | empty_res_o, dropped_o, out_last_o
// config    | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// Candidates are taken one per cycle while busy_o is low; a three-register decode
// pipeline feeds a row of cells that keeps the survivors sorted by score.
// An item with last set raises busy_o; once the pipeline drains, the suppression
// pass visits the row head by head: CMP_A, CMP_B, SHIFT for a surviving box, CMP_A,
// SHIFT for a suppressed one, FINAL once the head is empty; results are registered.
// Reset clears the row, the flags and the sequencer; no clearing pass is needed.
// Results are one-cycle strobes and the receiver cannot stall them.
module detection_box_decode_nms_top #(
  parameter int MaxBoxes      = dbn_pkg::MaxBoxesDef,
  parameter int CoordFracBits = dbn_pkg::CoordFracDef,
  parameter int PixelBits     = dbn_pkg::PixelBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dbn_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [dbn_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [dbn_pkg::CoordW-1:0]  coord_a_i,
  input  logic signed [dbn_pkg::CoordW-1:0]  coord_b_i,
  input  logic signed [dbn_pkg::CoordW-1:0]  coord_c_i,
  input  logic signed [dbn_pkg::CoordW-1:0]  coord_d_i,
  input  logic [dbn_pkg::ScoreW-1:0]         score_i,
  input  logic [dbn_pkg::ClassW-1:0]         class_id_i,
  input  logic                               last_i,
  output logic                               res_valid_o,
  output logic [dbn_pkg::OutPixW-1:0]        box_x1_o,
  output logic [dbn_pkg::OutPixW-1:0]        box_y1_o,
  output logic [dbn_pkg::OutPixW-1:0]        box_x2_o,
  output logic [dbn_pkg::OutPixW-1:0]        box_y2_o,
  output logic [dbn_pkg::ScoreW-1:0]         out_score_o,
  output logic [dbn_pkg::ClassW-1:0]         out_class_o,
  output logic                               empty_res_o,
  output logic                               dropped_o,
  output logic                               out_last_o
);
  import dbn_pkg::*;

  localparam int P    = PixelBits;
  localparam int EntW = ent_width(P);
  localparam int SL   = ent_score_lsb(P);
  localparam int CL   = ent_class_lsb(P);
  localparam int SB   = ent_supp_bit(P);
  localparam int VB   = ent_valid_bit(P);

  // Configuration registers.
  logic [ScoreW-1:0] conf_thr_q, iou_thr_q;
  logic              box_fmt_q;
  logic [PadW-1:0]   pad_x_q, pad_y_q;
  logic [ScaleW-1:0] inv_scale_q;
  logic [FrameW-1:0] frame_w_q, frame_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_thr_q  <= ScoreW'(16384);
      iou_thr_q   <= ScoreW'(29491);
      box_fmt_q   <= 1'b0;
      pad_x_q     <= '0;
      pad_y_q     <= '0;
      inv_scale_q <= ScaleW'(65536);
      frame_w_q   <= FrameW'(640);
      frame_h_q   <= FrameW'(640);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CONF_THR:  conf_thr_q  <= cfg_data_i[ScoreW-1:0];
        REG_IOU_THR:   iou_thr_q   <= cfg_data_i[ScoreW-1:0];
        REG_BOX_FMT:   box_fmt_q   <= cfg_data_i[0];
        REG_PAD_X:     pad_x_q     <= cfg_data_i[PadW-1:0];
        REG_PAD_Y:     pad_y_q     <= cfg_data_i[PadW-1:0];
        REG_INV_SCALE: inv_scale_q <= cfg_data_i[ScaleW-1:0];
        REG_FRAME_W:   frame_w_q   <= cfg_data_i[FrameW-1:0];
        REG_FRAME_H:   frame_h_q   <= cfg_data_i[FrameW-1:0];
        default:       conf_thr_q  <= conf_thr_q;
      endcase
    end
  end

  // Decode pipeline.
  dec_cfg_t        dcfg;
  logic            take, ins_ok, ins_last;
  logic [EntW-1:0] ins_ent;
  state_e          state_q, state_d;

  assign busy_o = (state_q != ST_RUN);
  assign take   = start_i && !busy_o;
  assign dcfg   = '{conf_thr: conf_thr_q, box_fmt: box_fmt_q, pad_x: pad_x_q,
                    pad_y: pad_y_q, inv_scale: inv_scale_q, frame_w: frame_w_q,
                    frame_h: frame_h_q};

  dbn_decode #(
    .CoordFracBits (CoordFracBits),
    .PixelBits     (PixelBits)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (dcfg),
    .take_i     (take),
    .coord_a_i  (coord_a_i),
    .coord_b_i  (coord_b_i),
    .coord_c_i  (coord_c_i),
    .coord_d_i  (coord_d_i),
    .score_i    (score_i),
    .class_i    (class_id_i),
    .last_i     (last_i),
    .ins_ok_o   (ins_ok),
    .ins_last_o (ins_last),
    .ins_ent_o  (ins_ent)
  );

  // Row of store cells; cell 0 holds the highest score.
  cell_ctrl_t      ctrl;
  logic [EntW-1:0] bcast;
  logic [EntW-1:0] ent [MaxBoxes];
  logic            ge  [MaxBoxes];
  logic [EntW-1:0] head;

  assign head  = ent[0];
  assign bcast = ((state_q == ST_RUN) || (state_q == ST_DRAIN)) ? ins_ent : head;

  for (genvar k = 0; k < MaxBoxes; k++) begin : g_cell
    logic [EntW-1:0] left_ent, right_ent;
    logic            left_ge;
    if (k == 0) begin : g_first
      assign left_ent = '0;
      assign left_ge  = 1'b1;
    end else begin : g_inner
      assign left_ent = ent[k-1];
      assign left_ge  = ge[k-1];
    end
    if (k == MaxBoxes - 1) begin : g_end
      assign right_ent = '0;
    end else begin : g_mid
      assign right_ent = ent[k+1];
    end
    dbn_cell #(
      .PixelBits (PixelBits)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .new_i     (bcast),
      .left_i    (left_ent),
      .left_ge_i (left_ge),
      .right_i   (right_ent),
      .ge_o      (ge[k]),
      .ent_o     (ent[k])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN:   if (take && last_i) state_d = ST_DRAIN;
      ST_DRAIN: if (ins_last) state_d = ST_CMP_A;
      ST_CMP_A: begin
        if (!head[VB]) begin
          state_d = ST_FINAL;
        end else if (head[SB]) begin
          state_d = ST_SHIFT;
        end else begin
          state_d = ST_CMP_B;
        end
      end
      ST_CMP_B: state_d = ST_SHIFT;
      ST_SHIFT: state_d = ST_CMP_A;
      ST_FINAL: state_d = ST_RUN;
      default:  state_d = ST_RUN;
    endcase
  end

  // Sequencer outputs.
  logic emit_head, emit_final;

  always_comb begin
    ctrl.op      = OP_HOLD;
    ctrl.iou_thr = iou_thr_q;
    emit_head    = 1'b0;
    emit_final   = 1'b0;
    unique case (state_q)
      ST_RUN, ST_DRAIN: if (ins_ok) ctrl.op = OP_INSERT;
      ST_CMP_A: begin
        if (head[VB] && !head[SB]) begin
          ctrl.op   = OP_CMP_A;
          emit_head = 1'b1;
        end
      end
      ST_CMP_B: ctrl.op = OP_CMP_B;
      ST_SHIFT: ctrl.op = OP_SHIFT;
      ST_FINAL: emit_final = 1'b1;
      default:  ctrl.op = OP_HOLD;
    endcase
  end

  // Control registers: state, overflow, pending and result strobes.
  logic overflow_q, pend_valid_q, res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      overflow_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (emit_head && pend_valid_q) || emit_final;
      if (ctrl.op == OP_INSERT && ent[MaxBoxes-1][VB]) begin
        overflow_q <= 1'b1;
      end else if (emit_final) begin
        overflow_q <= 1'b0;
      end
      if (emit_head) begin
        pend_valid_q <= 1'b1;
      end else if (emit_final) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  // A kept box waits one step so that the final one can be marked.
  logic [P-1:0]      pend_x1_q, pend_y1_q, pend_x2_q, pend_y2_q;
  logic [ScoreW-1:0] pend_score_q, res_score_q;
  logic [ClassW-1:0] pend_class_q, res_class_q;
  logic [OutPixW-1:0] res_x1_q, res_y1_q, res_x2_q, res_y2_q;
  logic               res_empty_q, res_drop_q, res_last_q;

  always_ff @(posedge clk_i) begin
    if (emit_head) begin
      pend_x1_q    <= head[P-1:0];
      pend_y1_q    <= head[2*P-1:P];
      pend_x2_q    <= head[3*P-1:2*P];
      pend_y2_q    <= head[4*P-1:3*P];
      pend_score_q <= head[SL+ScoreW-1:SL];
      pend_class_q <= head[CL+ClassW-1:CL];
    end
    if (emit_head || emit_final) begin
      res_drop_q <= overflow_q;
      res_last_q <= emit_final;
      if (pend_valid_q) begin
        res_x1_q    <= OutPixW'(pend_x1_q);
        res_y1_q    <= OutPixW'(pend_y1_q);
        res_x2_q    <= OutPixW'(pend_x2_q);
        res_y2_q    <= OutPixW'(pend_y2_q);
        res_score_q <= pend_score_q;
        res_class_q <= pend_class_q;
        res_empty_q <= 1'b0;
      end else begin
        res_x1_q    <= '0;
        res_y1_q    <= '0;
        res_x2_q    <= '0;
        res_y2_q    <= '0;
        res_score_q <= '0;
        res_class_q <= '0;
        res_empty_q <= 1'b1;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign box_x1_o    = res_x1_q;
  assign box_y1_o    = res_y1_q;
  assign box_x2_o    = res_x2_q;
  assign box_y2_o    = res_y2_q;
  assign out_score_o = res_score_q;
  assign out_class_o = res_class_q;
  assign empty_res_o = res_empty_q;
  assign dropped_o   = res_drop_q;
  assign out_last_o  = res_last_q;

`ifndef SYNTHESIS
  // The final result of a frame is followed by a quiet cycle.
  a_last_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_last_o |=> !res_valid_o)
    else $error("result directly after the final result of a frame");

  // An empty result is always the final one.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && empty_res_o |-> out_last_o)
    else $error("empty result not marked as final");

  // Taking the last candidate closes the input until the frame is done.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_i |=> busy_o)
    else $error("input not closed after the last candidate");

  // Results only appear while the suppression pass runs or right after it.
  a_res_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_o))
    else $error("result outside the suppression pass");
`endif

endmodule

/* hdl/dbn_decode.sv */
module dbn_decode #(
  parameter int CoordFracBits = dbn_pkg::CoordFracDef,
  parameter int PixelBits     = dbn_pkg::PixelBitsDef,
  localparam int EntW         = dbn_pkg::ent_width(PixelBits)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dbn_pkg::dec_cfg_t                  cfg_i,
  input  logic                               take_i,
  input  logic signed [dbn_pkg::CoordW-1:0]  coord_a_i,
  input  logic signed [dbn_pkg::CoordW-1:0]  coord_b_i,
  input  logic signed [dbn_pkg::CoordW-1:0]  coord_c_i,
  input  logic signed [dbn_pkg::CoordW-1:0]  coord_d_i,
  input  logic [dbn_pkg::ScoreW-1:0]         score_i,
  input  logic [dbn_pkg::ClassW-1:0]         class_i,
  input  logic                               last_i,
  output logic                               ins_ok_o,
  output logic                               ins_last_o,
  output logic [EntW-1:0]                    ins_ent_o
);
  import dbn_pkg::*;

  localparam int InShift  = CoordFracBits + 1;
  localparam int OutShift = CoordFracBits + 17;
  localparam int EdgeW    = 23;
  localparam int ProdW    = EdgeW + ScaleW + 1;
  localparam int LimW     = PixelBits + 1;
  localparam logic [LimW-1:0] PixMax = LimW'((1 << PixelBits) - 1);

  // Stage 1: box edges in half-fraction units, pad removed.
  logic signed [EdgeW-1:0] a2, b2, c2, d2, ce, de;
  logic signed [EdgeW-1:0] x1f, x2f, y1f, y2f, padx_e, pady_e;
  logic signed [EdgeW-1:0] e_q [4];
  logic [ScoreW-1:0]       s1_score_q;
  logic [ClassW-1:0]       s1_class_q;
  logic                    s1_ok_q, s1_last_q;

  always_comb begin
    a2 = EdgeW'(coord_a_i) <<< 1;
    b2 = EdgeW'(coord_b_i) <<< 1;
    c2 = EdgeW'(coord_c_i) <<< 1;
    d2 = EdgeW'(coord_d_i) <<< 1;
    ce = EdgeW'(coord_c_i);
    de = EdgeW'(coord_d_i);
    padx_e = $signed(EdgeW'(cfg_i.pad_x)) <<< InShift;
    pady_e = $signed(EdgeW'(cfg_i.pad_y)) <<< InShift;
    if (cfg_i.box_fmt) begin
      x1f = a2 - ce;
      x2f = a2 + ce;
      y1f = b2 - de;
      y2f = b2 + de;
    end else begin
      x1f = (a2 > c2) ? c2 : a2;
      x2f = (a2 > c2) ? a2 : c2;
      y1f = (b2 > d2) ? d2 : b2;
      y2f = (b2 > d2) ? b2 : d2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ok_q   <= 1'b0;
      s1_last_q <= 1'b0;
    end else begin
      s1_ok_q   <= take_i && (score_i >= cfg_i.conf_thr);
      s1_last_q <= take_i && last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q[0]     <= x1f - padx_e;
    e_q[1]     <= y1f - pady_e;
    e_q[2]     <= x2f - padx_e;
    e_q[3]     <= y2f - pady_e;
    s1_score_q <= score_i;
    s1_class_q <= class_i;
  end

  // Stage 2: scale every edge by the inverse letterbox scale.
  logic signed [ScaleW:0]  inv_s;
  logic signed [ProdW-1:0] p_q [4];
  logic [ScoreW-1:0]       s2_score_q;
  logic [ClassW-1:0]       s2_class_q;
  logic                    s2_ok_q, s2_last_q;

  assign inv_s = $signed({1'b0, cfg_i.inv_scale});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ok_q   <= 1'b0;
      s2_last_q <= 1'b0;
    end else begin
      s2_ok_q   <= s1_ok_q;
      s2_last_q <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      p_q[k] <= e_q[k] * inv_s;
    end
    s2_score_q <= s1_score_q;
    s2_class_q <= s1_class_q;
  end

  // Stage 3: clamp to the frame, one-pixel size test, truncate.
  logic [LimW-1:0]         limx, limy;
  logic signed [ProdW-1:0] hix, hiy, one_px;
  logic signed [ProdW-1:0] cl [4];
  logic [ProdW-1:0]        shf [4];
  logic                    big;
  logic [PixelBits-1:0]    bx_q [4];
  logic [ScoreW-1:0]       s3_score_q;
  logic [ClassW-1:0]       s3_class_q;
  logic                    s3_ok_q, s3_last_q;

  always_comb begin
    limx = (cfg_i.frame_w == '0) ? '0 : LimW'(cfg_i.frame_w - 1'b1);
    limy = (cfg_i.frame_h == '0) ? '0 : LimW'(cfg_i.frame_h - 1'b1);
    if ((cfg_i.frame_w != '0) && (FrameW'(cfg_i.frame_w - 1'b1) > FrameW'(PixMax))) begin
      limx = PixMax;
    end
    if ((cfg_i.frame_h != '0) && (FrameW'(cfg_i.frame_h - 1'b1) > FrameW'(PixMax))) begin
      limy = PixMax;
    end
    hix    = $signed(ProdW'(limx)) <<< OutShift;
    hiy    = $signed(ProdW'(limy)) <<< OutShift;
    one_px = $signed(ProdW'(1)) <<< OutShift;
    for (int k = 0; k < 4; k++) begin
      cl[k] = p_q[k];
      if (cl[k] > ((k % 2 == 0) ? hix : hiy)) begin
        cl[k] = (k % 2 == 0) ? hix : hiy;
      end
      if (cl[k] < 0) begin
        cl[k] = '0;
      end
      shf[k] = unsigned'(cl[k]) >> OutShift;
    end
    big = ((cl[2] - cl[0]) >= one_px) && ((cl[3] - cl[1]) >= one_px);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ok_q   <= 1'b0;
      s3_last_q <= 1'b0;
    end else begin
      s3_ok_q   <= s2_ok_q && big;
      s3_last_q <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      bx_q[k] <= shf[k][PixelBits-1:0];
    end
    s3_score_q <= s2_score_q;
    s3_class_q <= s2_class_q;
  end

  // Stage 4: box area, packed into a store entry for insertion.
  logic [2*PixelBits-1:0] area;

  assign area = (bx_q[2] - bx_q[0]) * (bx_q[3] - bx_q[1]);

  assign ins_ok_o   = s3_ok_q;
  assign ins_last_o = s3_last_q;
  assign ins_ent_o  = {1'b1, 1'b0, s3_class_q, s3_score_q, area,
                       bx_q[3], bx_q[2], bx_q[1], bx_q[0]};

endmodule

/* hdl/dbn_cell.sv */
module dbn_cell #(
  parameter int PixelBits = dbn_pkg::PixelBitsDef,
  localparam int EntW     = dbn_pkg::ent_width(PixelBits)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dbn_pkg::cell_ctrl_t  ctrl_i,
  input  logic [EntW-1:0]      new_i,
  input  logic [EntW-1:0]      left_i,
  input  logic                 left_ge_i,
  input  logic [EntW-1:0]      right_i,
  output logic                 ge_o,
  output logic [EntW-1:0]      ent_o
);
  import dbn_pkg::*;

  localparam int P     = PixelBits;
  localparam int AL    = ent_area_lsb(P);
  localparam int SL    = ent_score_lsb(P);
  localparam int CL    = ent_class_lsb(P);
  localparam int SB    = ent_supp_bit(P);
  localparam int VB    = ent_valid_bit(P);
  localparam int AreaW = 2 * P;
  localparam int CmpW  = 2 * P + ScoreW + 1;

  logic [EntW-1:0] ent_q, ent_d;
  logic [AreaW-1:0] inter_q, inter_d;
  logic             ok_q, ok_d;

  logic [P-1:0]  mx1, my1, mx2, my2, hx1, hy1, hx2, hy2, ix1, iy1, ix2, iy2;
  logic signed [P:0] iw, ih;
  logic [AreaW:0]    uni;
  logic [CmpW-1:0]   lhs, rhs;

  assign mx1 = ent_q[P-1:0];
  assign my1 = ent_q[2*P-1:P];
  assign mx2 = ent_q[3*P-1:2*P];
  assign my2 = ent_q[4*P-1:3*P];
  assign hx1 = new_i[P-1:0];
  assign hy1 = new_i[2*P-1:P];
  assign hx2 = new_i[3*P-1:2*P];
  assign hy2 = new_i[4*P-1:3*P];

  // Sorted order: this entry stays ahead of a new one with the same or lower score.
  assign ge_o  = ent_q[VB] && (ent_q[SL+ScoreW-1:SL] >= new_i[SL+ScoreW-1:SL]);
  assign ent_o = ent_q;

  // Intersection with the head box.
  always_comb begin
    ix1 = (mx1 > hx1) ? mx1 : hx1;
    iy1 = (my1 > hy1) ? my1 : hy1;
    ix2 = (mx2 < hx2) ? mx2 : hx2;
    iy2 = (my2 < hy2) ? my2 : hy2;
    iw  = $signed({1'b0, ix2}) - $signed({1'b0, ix1});
    ih  = $signed({1'b0, iy2}) - $signed({1'b0, iy1});
    ok_d    = ent_q[VB] && !ent_q[SB] && new_i[VB] && (iw > 0) && (ih > 0) &&
              (ent_q[CL+ClassW-1:CL] == new_i[CL+ClassW-1:CL]);
    inter_d = iw[P-1:0] * ih[P-1:0];
  end

  // Overlap ratio test by cross-multiplication.
  always_comb begin
    uni = (AreaW+1)'(ent_q[AL+AreaW-1:AL]) + (AreaW+1)'(new_i[AL+AreaW-1:AL]) -
          (AreaW+1)'(inter_q);
    lhs = CmpW'({inter_q, 16'h0000});
    rhs = ctrl_i.iou_thr * uni;
  end

  // Next entry for each broadcast operation.
  always_comb begin
    ent_d = ent_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (!ge_o) begin
          ent_d = left_ge_i ? new_i : left_i;
        end
      end
      OP_SHIFT: begin
        ent_d = right_i;
      end
      OP_CMP_B: begin
        if (ok_q && (uni != '0) && (lhs > rhs)) begin
          ent_d[SB] = 1'b1;
        end
      end
      default: begin
        ent_d = ent_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      ok_q  <= 1'b0;
    end else begin
      ent_q <= ent_d;
      if (ctrl_i.op == OP_CMP_A) begin
        ok_q <= ok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_CMP_A) begin
      inter_q <= inter_d;
    end
  end

endmodule
